// ===== rtl/dust_sensor_average_convert_top_macros.svh =====
// Assertion macros for the dust sensor averaging block.
// Depends on nothing; files that assert include it by name and supply clk and rst_n.
`ifndef DUST_SENSOR_AVERAGE_CONVERT_TOP_MACROS_SVH
`define DUST_SENSOR_AVERAGE_CONVERT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsac assertion failed");

// Next-cycle implication, disabled during reset.
`define DSAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsac assertion failed");

`endif

// ===== rtl/dsac_pkg.sv =====
// Shared types and constants for the dust sensor averaging block.
// Used by dsac_div and dust_sensor_average_convert_top; depends on nothing.
package dsac_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd0;
  localparam logic [1:0] REG_BASELINE_INIT = 2'd1;
  localparam logic [1:0] REG_SENSITIVITY   = 2'd2;

  // Field widths
  localparam int CNT_W   = 7;
  localparam int MV_W    = 13;
  localparam int SMP_W   = 10;
  localparam int TOTAL_W = 16;
  // Dividend width: 16-bit total times 5000 needs 29 bits
  localparam int NUM_W   = 29;

  // Reset values of the registers
  localparam logic [CNT_W-1:0] COUNT_RESET     = 7'd10;
  localparam logic [MV_W-1:0]  BASELINE_RESET  = 13'd600;
  localparam logic [MV_W-1:0]  SENSITIVITY_RST = 13'd500;

  // Conversion constants
  localparam logic [NUM_W-1:0] FULL_SCALE_MV = 29'd5000;
  localparam logic [NUM_W-1:0] DENSITY_SCALE = 29'd100;
  localparam logic [MV_W-1:0]  DUST_OFFSET   = 13'd70;
  localparam logic [MV_W-1:0]  MV_MAX        = 13'h1FFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_DIV,
    ST_DENS_START,
    ST_DENS_DIV,
    ST_HOLD
  } dsac_state_t;

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a quotient to the 13-bit range
  function automatic logic [MV_W-1:0] sat13(input logic [NUM_W-1:0] v);
    logic [MV_W-1:0] r;
    r = (|v[NUM_W-1:MV_W]) ? MV_MAX : v[MV_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/dsac_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dsac_pkg for the status struct.
module dsac_div
  import dsac_pkg::*;
#(
  parameter int NUM_W_P = 29,
  parameter int DEN_W_P = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W_P-1:0] num,
  input  logic [DEN_W_P-1:0] den,
  output logic [NUM_W_P-1:0] quo,
  output div_stat_t          stat
);

  localparam int STEP_W = (NUM_W_P > 1) ? $clog2(NUM_W_P) : 1;

  logic [NUM_W_P-1:0] num_r, num_nxt;
  logic [NUM_W_P-1:0] quo_r, quo_nxt;
  logic [DEN_W_P-1:0] rem_r, rem_nxt;
  logic [DEN_W_P-1:0] den_r, den_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic [DEN_W_P:0]   rem_sh;
  logic [DEN_W_P+1:0] diff;
  logic               ge;

  // One trial subtraction per cycle
  assign rem_sh = {rem_r, num_r[NUM_W_P-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = !diff[DEN_W_P+1];

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
      rem_nxt  = '0;
      step_nxt = STEP_W'(NUM_W_P - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = {num_r[NUM_W_P-2:0], 1'b0};
      quo_nxt  = {quo_r[NUM_W_P-2:0], ge};
      rem_nxt  = ge ? diff[DEN_W_P-1:0] : rem_sh[DEN_W_P-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/dust_sensor_average_convert_top.sv =====
// Dust sensor averaging and density conversion, top level.
// Depends on dsac_pkg, dsac_div and dust_sensor_average_convert_top_macros.svh.
//
// Each accepted item is one 10-bit converter sample; it is summed (saturating at 65535) into
// the registered total and in_ready stays high. The sample that completes a group of
// sample_count samples starts the conversion: the average in mV is
// total*5000/(SAMPLE_STEPS*count), the baseline is subtracted (and lowered to the average
// when the average falls below it), and density is dV*100/sensitivity_mv; dust_level is
// density minus 70, floored at zero. Both divisions run on one shared bit-serial divider
// at one quotient bit per cycle, so in_ready stays low from a group's last sample until
// the result is loaded. The result sits in an output register, and new samples are taken
// while it waits; a later result waits in ST_HOLD until that register is free. A
// sample_count of 0 acts as 1 and one above MAX_SAMPLES acts as MAX_SAMPLES. Writing
// baseline_init_mv loads the running baseline at once. cfg_ready is always high.
`include "dust_sensor_average_convert_top_macros.svh"

module dust_sensor_average_convert_top
  import dsac_pkg::*;
#(
  parameter int SAMPLE_STEPS = 1024,
  parameter int MAX_SAMPLES  = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [SMP_W-1:0] in_sample,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [MV_W-1:0] out_dust_level,
  output logic [MV_W-1:0] out_density,
  output logic [MV_W-1:0] out_average_mv,
  output logic            out_baseline_moved,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [MV_W-1:0] cfg_data
);

  localparam int DEN_W = $clog2(SAMPLE_STEPS + 1) + CNT_W;
  localparam logic [CNT_W-1:0] MAX_N =
    (MAX_SAMPLES > 127) ? 7'd127 : CNT_W'(MAX_SAMPLES);

  dsac_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r;
  logic [MV_W-1:0]    sens_r;
  logic [MV_W-1:0]    baseline_r, baseline_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   taken_r, taken_nxt;
  logic [MV_W-1:0]    avg_r, avg_nxt;
  logic [MV_W-1:0]    dv_r, dv_nxt;
  logic               moved_r, moved_nxt;
  logic [MV_W-1:0]    dens_r, dens_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [MV_W-1:0]    out_level_r, out_dens_r, out_avg_r;
  logic               out_moved_r;

  logic [CNT_W-1:0]   group_n;
  logic [MV_W-1:0]    sens_eff;
  logic [TOTAL_W:0]   sum;
  logic               in_fire;
  logic               cfg_fire;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quo;
  div_stat_t          div_stat;
  logic [MV_W-1:0]    quo_sat;

  // Effective group size and sensitivity
  always_comb begin
    group_n = count_r;
    if (group_n == '0) group_n = 7'd1;
    if (group_n > MAX_N) group_n = MAX_N;
  end
  assign sens_eff = (sens_r == '0) ? 13'd1 : sens_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign sum       = {1'b0, total_r} + {{(TOTAL_W + 1 - SMP_W){1'b0}}, in_sample};
  assign quo_sat   = sat13(div_quo);

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(total_r) * FULL_SCALE_MV;
    div_den   = DEN_W'(SAMPLE_STEPS) * DEN_W'(group_n);
    case (state_r)
      ST_AVG_START:  div_start = 1'b1;
      ST_DENS_START: begin
        div_start = 1'b1;
        div_num   = NUM_W'(dv_r) * DENSITY_SCALE;
        div_den   = DEN_W'(sens_eff);
      end
      default: ;
    endcase
  end

  dsac_div #(
    .NUM_W_P(NUM_W),
    .DEN_W_P(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .stat (div_stat)
  );

  // Sequencer: accumulate, average, subtract baseline, density, hand off
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    taken_nxt     = taken_r;
    baseline_nxt  = baseline_r;
    avg_nxt       = avg_r;
    dv_nxt        = dv_r;
    moved_nxt     = moved_r;
    dens_nxt      = dens_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          total_nxt = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
          taken_nxt = taken_r + 1'b1;
          if (taken_nxt >= group_n) state_nxt = ST_AVG_START;
        end
      end
      ST_AVG_START: begin
        total_nxt = '0;
        taken_nxt = '0;
        state_nxt = ST_AVG_DIV;
      end
      ST_AVG_DIV: begin
        if (div_stat.done) begin
          avg_nxt = quo_sat;
          if (quo_sat < baseline_r) begin
            dv_nxt       = '0;
            moved_nxt    = 1'b1;
            baseline_nxt = quo_sat;
          end else begin
            dv_nxt    = quo_sat - baseline_r;
            moved_nxt = 1'b0;
          end
          state_nxt = ST_DENS_START;
        end
      end
      ST_DENS_START: state_nxt = ST_DENS_DIV;
      ST_DENS_DIV: begin
        if (div_stat.done) begin
          dens_nxt  = quo_sat;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Writing the starting baseline reloads the running one
    if (cfg_fire && cfg_index == REG_BASELINE_INIT) baseline_nxt = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      taken_r     <= '0;
      baseline_r  <= BASELINE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      taken_r     <= taken_nxt;
      baseline_r  <= baseline_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      sens_r  <= SENSITIVITY_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: count_r <= cfg_data[CNT_W-1:0];
        REG_SENSITIVITY:  sens_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    avg_r   <= avg_nxt;
    dv_r    <= dv_nxt;
    moved_r <= moved_nxt;
    dens_r  <= dens_nxt;
    if (out_load) begin
      out_level_r <= (dens_r > DUST_OFFSET) ? dens_r - DUST_OFFSET : '0;
      out_dens_r  <= dens_r;
      out_avg_r   <= avg_r;
      out_moved_r <= moved_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dust_level     = out_level_r;
  assign out_density        = out_dens_r;
  assign out_average_mv     = out_avg_r;
  assign out_baseline_moved = out_moved_r;

  // The divider is free whenever samples are taken
  `DSAC_ASSERT_NOW(a_idle_div_free, in_ready, !div_stat.busy)
  // A division is only started on an idle divider
  `DSAC_ASSERT_NOW(a_start_free, div_start, !div_stat.busy)
  // Quotients only come back while the sequencer waits for them
  `DSAC_ASSERT_NOW(a_done_expected, div_stat.done,
                   (state_r == ST_AVG_DIV) || (state_r == ST_DENS_DIV))
  // A lowered baseline means no rise above it, hence no density
  `DSAC_ASSERT_NOW(a_moved_zero, out_valid_r && out_moved_r,
                   (out_dens_r == '0) && (out_level_r == '0))
  // Loading the output leaves the block ready for the next sample
  `DSAC_ASSERT_NEXT(a_load_idle, out_load, in_ready && out_valid_r)

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the dust sensor averaging and density conversion block.
// Drives samples and register writes, predicts each result, and compares it field by field.
// Depends on dsac_pkg and dust_sensor_average_convert_top.
`timescale 1ns / 1ps

module tb_top;
  import dsac_pkg::*;

  localparam int SAMPLE_STEPS  = 1024;
  localparam int MAX_SAMPLES   = 64;
  localparam int SETTLE_CYCLES = 100;     // covers the two divider passes with margin
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 500;

  typedef struct packed {
    logic [MV_W-1:0] dust_level;
    logic [MV_W-1:0] density;
    logic [MV_W-1:0] average_mv;
    logic            moved;
  } dust_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [MV_W-1:0]  reg_data;
    logic [SMP_W-1:0] sample;
    bit               typed;
    dust_result_t     want;
  } stim_row_t;

  // DUT ports
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [SMP_W-1:0] in_sample = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [MV_W-1:0]  out_dust_level;
  logic [MV_W-1:0]  out_density;
  logic [MV_W-1:0]  out_average_mv;
  logic             out_baseline_moved;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [MV_W-1:0]  cfg_data = '0;

  // Predictor copy of registers and state
  logic [CNT_W-1:0] count_reg;
  logic [MV_W-1:0]  sens_reg;
  int               acc_total;
  int               acc_taken;
  int               baseline;

  dust_result_t     pending_results[$];
  stim_row_t        dir_rows[$];

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  logic hold_off = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int moved_seen = 0;
  int cycle_count = 0;

  dust_sensor_average_convert_top #(
    .SAMPLE_STEPS(SAMPLE_STEPS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dust_level    (out_dust_level),
    .out_density       (out_density),
    .out_average_mv    (out_average_mv),
    .out_baseline_moved(out_baseline_moved),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Register write as seen by the predictor
  function automatic void apply_reg(input logic [1:0] idx, input logic [MV_W-1:0] data);
    case (idx)
      REG_SAMPLE_COUNT: count_reg = data[CNT_W-1:0];
      REG_BASELINE_INIT: baseline = int'(data);
      REG_SENSITIVITY: sens_reg = data;
      default: ;
    endcase
  endfunction

  // Accumulate one sample; returns 1 with the converted result when a group completes
  function automatic bit convert_sample(input logic [SMP_W-1:0] s, output dust_result_t r);
    int n;
    int sens;
    longint avg;
    longint dv;
    longint dens;
    bit moved;
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    acc_total = acc_total + int'(s);
    if (acc_total > 65535) acc_total = 65535;
    if (acc_taken < 255) acc_taken++;
    r = '0;
    if (acc_taken < n) return 1'b0;

    avg = (longint'(acc_total) * 5000) / (longint'(SAMPLE_STEPS) * n);
    if (avg > 8191) avg = 8191;
    acc_total = 0;
    acc_taken = 0;

    // below baseline: clamp dV and let the baseline follow
    moved = 1'b0;
    if (avg < baseline) begin
      dv = 0;
      baseline = int'(avg);
      moved = 1'b1;
    end else begin
      dv = avg - baseline;
    end

    sens = (sens_reg == 0) ? 1 : int'(sens_reg);
    dens = (dv * 100) / sens;
    if (dens > 8191) dens = 8191;

    r.dust_level = (dens > 70) ? MV_W'(dens - 70) : '0;
    r.density    = MV_W'(dens);
    r.average_mv = MV_W'(avg);
    r.moved      = moved;
    return 1'b1;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [MV_W-1:0] data);
    stim_row_t row;
    row = '{ROW_CFG, idx, data, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t smp_row(input logic [SMP_W-1:0] s);
    stim_row_t row;
    row = '{ROW_SAMPLE, '0, '0, s, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t exp_row(input logic [SMP_W-1:0] s, input int lvl, input int dens,
                                        input int avg, input bit moved);
    stim_row_t row;
    row = '{ROW_SAMPLE, '0, '0, s, 1'b1, '{MV_W'(lvl), MV_W'(dens), MV_W'(avg), moved}};
    return row;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offer one sample item, with random idle cycles in front of it
  task automatic drive_sample(input logic [SMP_W-1:0] s, input bit typed,
                              input dust_result_t want);
    dust_result_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (convert_sample(s, r)) pending_results.push_back(typed ? want : r);
  endtask

  // Drain all results and let the block go quiet before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [MV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    @(posedge clk);
  endtask

  // Result receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    wait (hold_req);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_baseline_moved) moved_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: level %0d density %0d avg %0d moved %0d",
                 $time, out_dust_level, out_density, out_average_mv, out_baseline_moved);
        errors++;
      end else begin
        dust_result_t want;
        want = pending_results.pop_front();
        check_field("dust_level", int'(want.dust_level), int'(out_dust_level));
        check_field("density", int'(want.density), int'(out_density));
        check_field("average_mv", int'(want.average_mv), int'(out_average_mv));
        check_field("baseline_moved", int'(want.moved), int'(out_baseline_moved));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int rand_items;
    int phase;
    int cnt;
    int cnt_eff;
    int n_items;
    int r;
    logic [SMP_W-1:0] s;

    count_reg     = COUNT_RESET;
    sens_reg      = SENSITIVITY_RST;
    acc_total     = 0;
    acc_taken     = 0;
    baseline      = int'(BASELINE_RESET);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct    = 36;
    sink_stall_pct = 47;

    // Directed part: reset values, extremes and the corner cases
    repeat (9) dir_rows.push_back(smp_row(10'd1023));
    dir_rows.push_back(exp_row(10'd1023, 809, 879, 4995, 1'b0));
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 13'd1));
    dir_rows.push_back(cfg_row(REG_BASELINE_INIT, 13'd0));
    dir_rows.push_back(cfg_row(REG_SENSITIVITY, 13'd100));
    dir_rows.push_back(exp_row(10'd0, 0, 0, 0, 1'b0));          // equal to a zero baseline
    dir_rows.push_back(exp_row(10'd1023, 4925, 4995, 4995, 1'b0));
    dir_rows.push_back(cfg_row(REG_SENSITIVITY, 13'd0));        // zero sensitivity, saturates
    dir_rows.push_back(exp_row(10'd1023, 8121, 8191, 4995, 1'b0));
    dir_rows.push_back(cfg_row(REG_BASELINE_INIT, 13'h1FFF));   // baseline loads at once
    dir_rows.push_back(exp_row(10'd512, 0, 0, 2500, 1'b1));
    dir_rows.push_back(exp_row(10'd512, 0, 0, 2500, 1'b0));     // equal voltage
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 13'd0));       // count of zero acts as one
    dir_rows.push_back(cfg_row(REG_SENSITIVITY, 13'h1FFF));
    dir_rows.push_back(smp_row(10'd1023));
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 13'd2));
    dir_rows.push_back(cfg_row(REG_SENSITIVITY, 13'd100));
    dir_rows.push_back(cfg_row(REG_BASELINE_INIT, 13'd0));
    dir_rows.push_back(smp_row(10'd100));
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 13'd1));       // count lowered mid-group
    dir_rows.push_back(smp_row(10'd200));
    dir_rows.push_back(cfg_row(REG_SAMPLE_COUNT, 13'd3));
    dir_rows.push_back(smp_row(10'd1023));
    dir_rows.push_back(smp_row(10'd0));
    dir_rows.push_back(smp_row(10'd1023));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        drive_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part: phases of register settings, each followed by a run of samples
    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < RANDOM_ITEMS / 3) begin
        src_gap_pct    = 36;
        sink_stall_pct = 47;
      end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
        src_gap_pct    = 47;
        sink_stall_pct = 36;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      settle();

      r = $urandom_range(99);
      if (r < 5) cnt = 0;
      else if (r < 10) cnt = MAX_SAMPLES;
      else if (r < 13) cnt = $urandom_range(MAX_SAMPLES + 1, 127);
      else if (r < 20) cnt = $urandom_range(9, 32);
      else cnt = $urandom_range(1, 8);
      // long hold-off phase: short groups so the block backs up into its input
      if (phase == 2) cnt = 2;
      write_reg(REG_SAMPLE_COUNT, MV_W'(cnt));

      r = $urandom_range(99);
      if (r < 45) write_reg(REG_BASELINE_INIT, MV_W'($urandom_range(0, 1500)));
      else if (r < 60) write_reg(REG_BASELINE_INIT, MV_W'($urandom_range(0, 8191)));

      r = $urandom_range(99);
      if (r < 40) write_reg(REG_SENSITIVITY, MV_W'($urandom_range(100, 1000)));
      else if (r < 55) write_reg(REG_SENSITIVITY, MV_W'($urandom_range(0, 8191)));
      else if (r < 60) write_reg(REG_SENSITIVITY, '0);

      cnt_eff = (cnt == 0) ? 1 : (cnt > MAX_SAMPLES) ? MAX_SAMPLES : cnt;
      if (cnt_eff > 16) n_items = cnt_eff + $urandom_range(0, 3);
      else n_items = cnt_eff * $urandom_range(1, 5) + $urandom_range(0, 2);
      if (phase == 2) begin
        n_items = 60;
        hold_req = 1'b1;
      end

      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(99);
        if (r < 8) s = '0;
        else if (r < 16) s = '1;
        else s = SMP_W'($urandom_range(0, 1023));
        drive_sample(s, 1'b0, '0);
        rand_items++;
      end
      phase++;
    end

    settle();
    $display("Sent %0d samples over %0d random phases plus the directed table.",
             items_sent, phase);
    $display("Checked %0d results, %0d with the baseline moved, %0d errors.",
             results_seen, moved_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== dust_sensor_average_convert_top.f =====
+incdir+rtl
rtl/dsac_pkg.sv
rtl/dsac_div.sv
rtl/dust_sensor_average_convert_top.sv
sim/tb_top.sv
